>>> rtl/scfd_pkg.sv
// shared constants and types for the sum-checked frame deframer
`timescale 1ns / 1ps
`default_nettype none

package scfd_pkg;

  // framing constants
  localparam logic [7:0] HeaderByte   = 8'hA5;
  localparam int unsigned BodyDataLen = 9;
  localparam int unsigned IdxW        = $clog2(BodyDataLen + 1);
  localparam logic [IdxW-1:0] CsumIdx = IdxW'(BodyDataLen);

  // result kinds
  typedef enum logic [1:0] {
    KindAttitude = 2'd0,
    KindSpeed    = 2'd1,
    KindUnknown  = 2'd2,
    KindCsumErr  = 2'd3
  } frame_kind_e;

  // config register indexes
  typedef enum logic [0:0] {
    RegAttitudeId = 1'b0,
    RegSpeedId    = 1'b1
  } cfg_reg_e;

  // output payload
  typedef struct packed {
    logic [7:0]         shoot_code;
    logic [7:0]         mode_code;
    logic signed [15:0] speed_value;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_x;
    logic [7:0]         frame_id;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/sum_checked_frame_deframer.sv
// header byte frame deframer with 8-bit additive checksum
//
// Usage: link bytes enter on the s_axis channel, one item per byte. Bytes are
// skipped until the header 0xA5; then ten body bytes are collected (nine data
// bytes and a checksum byte). On the checksum byte one result item leaves on
// the m_axis channel: m_axis_tuser carries the frame kind (attitude, speed
// and mode, unknown id, checksum error), m_axis_tdata the id and decoded
// fields, zero where they do not apply.
// Latency: the result is valid the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle while s_axis_tready is high; the frame state and a single output
// register are updated from the accepted byte in one step.
// Stall: while a result waits and m_axis_tready is low, s_axis_tready is low;
// when the result is taken a new byte can be accepted in the same cycle.
// Reset: hunting for a header, no result pending, attitude id 0, speed id 1.
// The id registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them
// only while the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_frame_deframer (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic [0:0]   cfg_idx_i,
  input  wire logic [7:0]   cfg_data_i,
  // input bytes
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // rx_byte
  // result items
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // frame_id[7:0], quat_x[23:8], quat_y[39:24], quat_z[55:40], quat_w[71:56],
  // speed_value[87:72], mode_code[95:88], shoot_code[103:96]
  output logic [103:0]      m_axis_tdata,
  output logic [1:0]        m_axis_tuser    // frame_kind
);

  localparam int unsigned IdxW = scfd_pkg::IdxW;

  logic [7:0]            att_id_q, spd_id_q;
  logic                  in_frame_q, in_frame_d;
  logic [IdxW-1:0]       body_idx_q, body_idx_d;
  logic [7:0]            sum_q, sum_d;
  logic [7:0]            body_q [scfd_pkg::BodyDataLen];
  logic                  out_valid_q, out_valid_d;
  scfd_pkg::result_t     res_q, res_d;
  scfd_pkg::frame_kind_e kind_q, kind_d;
  logic                  s_accept, frame_done;
  logic [7:0]            rx_byte;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign frame_done    = s_accept && in_frame_q && (body_idx_q == scfd_pkg::CsumIdx);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_id_q <= 8'd0;
      spd_id_q <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        scfd_pkg::RegAttitudeId: att_id_q <= cfg_data_i;
        scfd_pkg::RegSpeedId:    spd_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame state next value
  always_comb begin
    in_frame_d = in_frame_q;
    body_idx_d = body_idx_q;
    sum_d      = sum_q;
    if (s_accept) begin
      if (!in_frame_q) begin
        if (rx_byte == scfd_pkg::HeaderByte) begin
          in_frame_d = 1'b1;
          body_idx_d = '0;
          sum_d      = 8'd0;
        end
      end else if (body_idx_q != scfd_pkg::CsumIdx) begin
        sum_d      = sum_q + rx_byte;
        body_idx_d = body_idx_q + 1'b1;
      end else begin
        in_frame_d = 1'b0;
        body_idx_d = '0;
        sum_d      = 8'd0;
      end
    end
  end

  // result decode from the stored body and the checksum byte
  always_comb begin
    res_d          = '0;
    res_d.frame_id = body_q[0];
    if (sum_q != rx_byte) begin
      kind_d = scfd_pkg::KindCsumErr;
    end else if (body_q[0] == att_id_q) begin
      kind_d       = scfd_pkg::KindAttitude;
      res_d.quat_x = {body_q[1], body_q[2]};
      res_d.quat_y = {body_q[3], body_q[4]};
      res_d.quat_z = {body_q[5], body_q[6]};
      res_d.quat_w = {body_q[7], body_q[8]};
    end else if (body_q[0] == spd_id_q) begin
      kind_d            = scfd_pkg::KindSpeed;
      res_d.speed_value = {body_q[1], body_q[2]};
      res_d.mode_code   = body_q[3];
      res_d.shoot_code  = body_q[4];
    end else begin
      kind_d = scfd_pkg::KindUnknown;
    end
  end

  // output valid next value
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (frame_done) begin
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      body_idx_q  <= '0;
      sum_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      body_idx_q  <= body_idx_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // body byte store
  always_ff @(posedge clk_i) begin
    if (s_accept && in_frame_q && (body_idx_q != scfd_pkg::CsumIdx)) begin
      body_q[body_idx_q] <= rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      res_q  <= res_d;
      kind_q <= kind_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = kind_q;

`ifndef SYNTHESIS
  // body index never passes the checksum slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    body_idx_q <= scfd_pkg::CsumIdx)
    else $error("body index out of range");

  // while hunting the index stays cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (body_idx_q == '0))
    else $error("index not cleared while hunting");

  // a checksum byte always yields a pending result and ends the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> (m_axis_tvalid && !in_frame_q))
    else $error("frame end without result");

  // a checksum error carries only the id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == scfd_pkg::KindCsumErr))
      |-> (m_axis_tdata[103:8] == '0))
    else $error("checksum error result has payload");
`endif

endmodule

`default_nettype wire
